// ----- rtl/fpp_pkg.sv -----
// shared types and constants of the flash page record packer
// no dependencies
package fpp_pkg;

  localparam int DEF_PAGE_BYTES = 256;
  localparam int DEF_PAGE_COUNT = 256;
  localparam int CMD_DEPTH      = 2;

  localparam logic [15:0] MAX_RECORD = 16'h00FF;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_PROBE = 2'd1;
  localparam logic [1:0] ACT_DATA  = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WORD   = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TOO_LONG = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_KEEP     = 3'd3,
    ST_FOUND    = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef struct packed {
    logic        dump;
    status_t     status;
    logic [7:0]  page;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WORD,
    BK_STATUS
  } bk_state_t;

endpackage

// ----- rtl/fpp_in_if.sv -----
// input channel of the packer: one start, probe result or log byte per beat
// no dependencies
interface fpp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  data_byte;
  logic [15:0] record_size;

  modport source (output valid, action, data_byte, record_size, input ready);
  modport sink   (input valid, action, data_byte, record_size, output ready);
endinterface

// ----- rtl/fpp_out_if.sv -----
// result channel of the packer: status items and page words
// depends on fpp_pkg
interface fpp_out_if
  import fpp_pkg::*;
;
  logic        valid;
  logic        ready;
  logic        kind;
  status_t     status;
  logic [7:0]  page_number;
  logic [4:0]  word_index;
  logic [63:0] page_word;
  logic        last;

  modport source (output valid, kind, status, page_number, word_index, page_word, last,
                  input ready);
  modport sink   (input valid, kind, status, page_number, word_index, page_word, last,
                  output ready);
endinterface

// ----- rtl/flash_page_record_packer.sv -----
// top level of the flash page record packer: front, command queue, page ram, back
// depends on fpp_pkg, fpp_in_if, fpp_out_if, fpp_front, fpp_queue, fpp_ram, fpp_back
//
// channel   dir  beat contents
// bytes     in   action, data_byte, record_size
// results   out  kind, status, page_number, word_index, page_word, last
//
// a beat that gives only a status item passes through the command queue and then
// the output register; status items stream at one per cycle while results is ready
// a page commit reads the page ram one word at a time, BK_READ then BK_WORD for
// each word, then a status item; bytes is held not ready until the commit ends
// reset is synchronous and clears all control state; the page ram needs no clear
// either side may stall at any time; the output register holds a beat until taken
module flash_page_record_packer
  import fpp_pkg::*;
#(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  parameter int PAGE_COUNT = DEF_PAGE_COUNT
) (
  input  logic      clk,
  input  logic      rst,
  fpp_in_if.sink    bytes,
  fpp_out_if.source results
);

  localparam int NWORDS = (PAGE_BYTES + 7) / 8;
  localparam int AW     = $clog2(NWORDS);

  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [63:0]   rdata;
  logic          push;
  cmd_t          cmd;
  logic          full;
  logic          pop;
  logic          empty;
  cmd_t          head;
  logic          dump_done;

  fpp_front #(
    .PAGE_BYTES (PAGE_BYTES),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .push      (push),
    .cmd       (cmd),
    .full      (full),
    .dump_done (dump_done)
  );

  fpp_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd),
    .full  (full),
    .pop   (pop),
    .empty (empty),
    .head  (head)
  );

  fpp_ram #(
    .WIDTH (64),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  fpp_back #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata),
    .dump_done (dump_done),
    .results   (results)
  );

endmodule

// ----- rtl/fpp_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module fpp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/fpp_queue.sv -----
// short command queue between front and back of the packer
// depends on fpp_pkg
module fpp_queue
  import fpp_pkg::*;
#(
  parameter int DEPTH = CMD_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/fpp_front.sv -----
// front end: accepts beats, tracks probe and fill state, packs bytes into words
// depends on fpp_pkg and fpp_in_if
module fpp_front
  import fpp_pkg::*;
#(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES,
  parameter int PAGE_COUNT = DEF_PAGE_COUNT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  fpp_in_if.sink                               bytes,
  output logic                                 we,
  output logic [$clog2((PAGE_BYTES+7)/8)-1:0]  waddr,
  output logic [63:0]                          wdata,
  output logic                                 push,
  output cmd_t                                 cmd,
  input  logic                                 full,
  input  logic                                 dump_done
);

  localparam int AW    = $clog2((PAGE_BYTES + 7) / 8);
  localparam int FP_W  = $clog2(PAGE_BYTES);
  localparam int WP_W  = $clog2(PAGE_COUNT);
  localparam int PP_W  = $clog2(PAGE_COUNT + 1);
  localparam int EXT_W = (PP_W > 8) ? PP_W : 8;

  logic [FP_W-1:0]  fill, fill_next;
  logic [WP_W-1:0]  wp, wp_next;
  logic [PP_W-1:0]  probe, probe_next;
  logic             locked, locked_next;
  logic [63:0]      acc, acc_next;
  logic             busy;
  logic             accept;
  logic [63:0]      merged;
  logic [PP_W-1:0]  probe_inc;
  logic [EXT_W-1:0] wp_ext, probe_ext, inc_ext;
  logic             probing;
  logic             probe_ended;

  assign bytes.ready = !full && !busy;
  assign accept      = bytes.valid && bytes.ready;

  assign probe_inc   = probe + 1'b1;
  assign wp_ext      = EXT_W'(wp);
  assign probe_ext   = EXT_W'(probe);
  assign inc_ext     = EXT_W'(probe_inc);
  assign probing     = (probe < PP_W'(PAGE_COUNT));
  assign probe_ended = !probing;

  always_comb begin
    merged = acc;
    merged[{fill[2:0], 3'b000} +: 8] = bytes.data_byte;
  end

  assign waddr = AW'(fill >> 3);
  assign wdata = merged;

  always_comb begin
    fill_next   = fill;
    wp_next     = wp;
    probe_next  = probe;
    locked_next = locked;
    acc_next    = acc;
    we          = 1'b0;
    push        = accept;
    cmd.dump    = 1'b0;
    cmd.status  = ST_IGNORED;
    cmd.page    = wp_ext[7:0];
    if (accept) begin
      priority if (bytes.action == ACT_START) begin
        fill_next   = FP_W'(1);
        wp_next     = '0;
        probe_next  = '0;
        locked_next = 1'b0;
        acc_next    = '0;
        cmd.status  = ST_OK;
        cmd.page    = '0;
      end else if (bytes.action == ACT_PROBE) begin
        priority if (probe_ended) begin
          cmd.status = ST_IGNORED;
        end else if (bytes.data_byte != 8'h00) begin
          wp_next    = WP_W'(probe);
          probe_next = PP_W'(PAGE_COUNT);
          cmd.status = ST_FOUND;
          cmd.page   = probe_ext[7:0];
        end else if (probe_inc == PP_W'(PAGE_COUNT)) begin
          probe_next  = PP_W'(PAGE_COUNT);
          locked_next = 1'b1;
          cmd.status  = ST_FULL;
        end else begin
          probe_next = probe_inc;
          cmd.status = ST_KEEP;
          cmd.page   = inc_ext[7:0];
        end
      end else if (bytes.action != ACT_DATA || locked || probing) begin
        cmd.status = ST_IGNORED;
      end else if (bytes.record_size > MAX_RECORD) begin
        cmd.status = ST_TOO_LONG;
      end else begin
        cmd.status = ST_OK;
        if (fill[2:0] == 3'd7 || fill == FP_W'(PAGE_BYTES - 1)) begin
          we       = 1'b1;
          acc_next = '0;
        end else begin
          acc_next = merged;
        end
        if (fill == FP_W'(PAGE_BYTES - 1)) begin
          fill_next = FP_W'(1);
          cmd.dump  = 1'b1;
          if (wp == WP_W'(PAGE_COUNT - 1)) begin
            wp_next     = '0;
            locked_next = 1'b1;
            cmd.status  = ST_FULL;
          end else begin
            wp_next = wp + 1'b1;
          end
        end else begin
          fill_next = fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= FP_W'(1);
      wp     <= '0;
      probe  <= '0;
      locked <= 1'b0;
      busy   <= 1'b0;
      acc    <= '0;
    end else begin
      acc    <= acc_next;
      fill   <= fill_next;
      wp     <= wp_next;
      probe  <= probe_next;
      locked <= locked_next;
      if (push && cmd.dump) begin
        busy <= 1'b1;
      end else if (dump_done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/fpp_back.sv -----
// back end: turns queued commands into status items and page word dumps
// depends on fpp_pkg and fpp_out_if
module fpp_back
  import fpp_pkg::*;
#(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 empty,
  input  cmd_t                                 head,
  output logic                                 pop,
  output logic                                 re,
  output logic [$clog2((PAGE_BYTES+7)/8)-1:0]  raddr,
  input  logic [63:0]                          rdata,
  output logic                                 dump_done,
  fpp_out_if.source                            results
);

  localparam int NWORDS = (PAGE_BYTES + 7) / 8;
  localparam int AW     = $clog2(NWORDS);
  localparam int EXT_W  = (AW > 5) ? AW : 5;

  bk_state_t        state, state_next;
  logic [AW-1:0]    cnt;
  logic [EXT_W-1:0] cnt_ext;
  logic             out_free;
  logic             load_word;
  logic             load_status;
  logic             last_word;

  logic             valid;
  logic             kind;
  status_t          status;
  logic [7:0]       page_number;
  logic [4:0]       word_index;
  logic [63:0]      page_word;
  logic             last;

  assign results.valid       = valid;
  assign results.kind        = kind;
  assign results.status      = status;
  assign results.page_number = page_number;
  assign results.word_index  = word_index;
  assign results.page_word   = page_word;
  assign results.last        = last;

  assign out_free  = !valid || results.ready;
  assign last_word = (cnt == AW'(NWORDS - 1));
  assign cnt_ext   = EXT_W'(cnt);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!empty && head.dump) begin
          state_next = BK_READ;
        end
      end
      BK_READ: begin
        state_next = BK_WORD;
      end
      BK_WORD: begin
        if (out_free) begin
          state_next = last_word ? BK_STATUS : BK_READ;
        end
      end
      BK_STATUS: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    re          = 1'b0;
    raddr       = cnt;
    load_word   = 1'b0;
    load_status = 1'b0;
    dump_done   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        load_status = out_free && !empty && !head.dump;
      end
      BK_READ: begin
        re = 1'b1;
      end
      BK_WORD: begin
        load_word = out_free;
      end
      BK_STATUS: begin
        load_status = out_free;
        dump_done   = out_free;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  assign pop = load_status;

  always_ff @(posedge clk) begin
    if (load_word) begin
      kind        <= KIND_WORD;
      status      <= ST_OK;
      page_number <= head.page;
      word_index  <= cnt_ext[4:0];
      page_word   <= rdata;
      last        <= 1'b0;
    end else if (load_status) begin
      kind        <= KIND_STATUS;
      status      <= head.status;
      page_number <= head.page;
      word_index  <= '0;
      page_word   <= '0;
      last        <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      cnt   <= '0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_status) begin
        cnt <= '0;
      end else if (load_word) begin
        cnt <= cnt + 1'b1;
      end
      if (load_word || load_status) begin
        valid <= 1'b1;
      end else if (results.ready) begin
        valid <= 1'b0;
      end
    end
  end

endmodule
